@@ rtl/core/usrb_pkg.sv @@
// ----------------------------------------------------------------------------
// usrb_pkg
// Shared sizes, codes and helper functions of the serial-over-USB ring bridge.
// ----------------------------------------------------------------------------
package usrb_pkg;

    localparam int RX_DEPTH     = 128;
    localparam int TX_DEPTH     = 256;
    localparam int PACKET_BYTES = 64;

    localparam int RX_AW  = $clog2(RX_DEPTH);
    localparam int RX_AW1 = RX_AW + 1;
    localparam int TX_AW  = $clog2(TX_DEPTH);
    localparam int CNT_W  = $clog2(PACKET_BYTES);

    localparam int MODE_W = 3;
    localparam int KIND_W = 3;
    localparam int DATA_W = 8;
    localparam int WAIT_W = 16;

    localparam logic [WAIT_W-1:0] WAIT_TICKS_RESET = WAIT_W'(20);

    typedef enum logic [MODE_W-1:0] {
        MODE_RX_BYTE  = 3'd0,
        MODE_READ     = 3'd1,
        MODE_WRITE    = 3'd2,
        MODE_FLUSH    = 3'd3,
        MODE_EP_RESET = 3'd4,
        MODE_DROP_TX  = 3'd5,
        MODE_REARM    = 3'd6,
        MODE_TICK     = 3'd7
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE       = 3'd0,
        KIND_READ_BYTE  = 3'd1,
        KIND_READ_EMPTY = 3'd2,
        KIND_PKT_BYTE   = 3'd3,
        KIND_ZLP        = 3'd4,
        KIND_WR_ACCEPT  = 3'd5,
        KIND_WR_DROP    = 3'd6,
        KIND_WR_WAIT    = 3'd7
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;    // capture the input item
        logic exec;     // apply the item's update
        logic rx_emit;  // deliver the fetched receive byte
        logic tx_emit;  // deliver the fetched packet byte
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_mode mode;
        logic  rx_avail;
        logic  flush_go;
        logic  tx_avail;
        logic  tx_last;
        logic  out_free;
    } t_dp_status;

    function automatic logic [RX_AW-1:0] rx_ptr_next(input logic [RX_AW-1:0] p);
        return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + RX_AW'(1);
    endfunction

    function automatic logic [TX_AW-1:0] tx_ptr_next(input logic [TX_AW-1:0] p);
        return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + TX_AW'(1);
    endfunction

    // True when at least one packet of free slots remains in the receive ring.
    function automatic logic rx_room_ok(input logic [RX_AW-1:0] rd,
                                        input logic [RX_AW-1:0] wr);
        logic [RX_AW:0] space;
        if (rd > wr) begin
            space = {1'b0, rd} - {1'b0, wr} - RX_AW1'(1);
        end else begin
            space = {1'b0, rd} + RX_AW1'(RX_DEPTH) - {1'b0, wr} - RX_AW1'(1);
        end
        return (space >= RX_AW1'(PACKET_BYTES));
    endfunction

endpackage

@@ rtl/core/usrb_if.sv @@
// ----------------------------------------------------------------------------
// usrb_in_if / usrb_out_if
// Valid/ready channels for input items and result items of the ring bridge.
// ----------------------------------------------------------------------------
interface usrb_in_if import usrb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] byte_in;
    logic              packet_end;
    logic              endpoint_ready;
    logic              port_open;

    modport source (output valid, mode, byte_in, packet_end, endpoint_ready,
                    port_open, input ready);
    modport sink   (input valid, mode, byte_in, packet_end, endpoint_ready,
                    port_open, output ready);
endinterface

interface usrb_out_if import usrb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] byte_out;
    logic              last;
    logic              rx_accepting;

    modport source (output valid, kind, byte_out, last, rx_accepting, input ready);
    modport sink   (input valid, kind, byte_out, last, rx_accepting, output ready);
endinterface

@@ rtl/core/usrb_ram.sv @@
// ----------------------------------------------------------------------------
// usrb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module usrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/usrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// usrb_ctrl
// Sequencer of the ring bridge: accepts items and steps the datapath through
// execution, memory fetches and result delivery.
// ----------------------------------------------------------------------------
module usrb_ctrl import usrb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RX_FETCH,
        S_RX_EMIT,
        S_TX_FETCH,
        S_TX_EMIT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_in_ready;
    t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (r_in_ready && i_in_valid) begin
                    cmd.latch = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.out_free) begin
                    cmd.exec = 1'b1;
                    if (i_status.mode == MODE_READ && i_status.rx_avail) begin
                        n_state = S_RX_FETCH;
                    end else if (i_status.mode == MODE_FLUSH && i_status.flush_go &&
                                 i_status.tx_avail) begin
                        n_state = S_TX_FETCH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RX_FETCH: begin
                n_state = S_RX_EMIT;
            end
            S_RX_EMIT: begin
                if (i_status.out_free) begin
                    cmd.rx_emit = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_TX_FETCH: begin
                n_state = S_TX_EMIT;
            end
            S_TX_EMIT: begin
                if (i_status.out_free) begin
                    cmd.tx_emit = 1'b1;
                    n_state     = i_status.tx_last ? S_IDLE : S_TX_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd      = cmd;

endmodule

@@ rtl/core/usrb_dp.sv @@
// ----------------------------------------------------------------------------
// usrb_dp
// Datapath of the ring bridge: ring pointers, flags, wait deadline, the two
// ring memories and the result register.
// ----------------------------------------------------------------------------
module usrb_dp import usrb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WAIT_W-1:0] i_cfg_wdata,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [DATA_W-1:0] i_byte_in,
    input  logic              i_packet_end,
    input  logic              i_endpoint_ready,
    input  logic              i_port_open,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [KIND_W-1:0] o_kind,
    output logic [DATA_W-1:0] o_byte_out,
    output logic              o_last,
    output logic              o_rx_accepting
);

    // Captured item.
    t_mode             r_mode;
    logic [DATA_W-1:0] r_byte;
    logic              r_pend;
    logic              r_ep_ready;
    logic              r_open;

    // Control state and its next values.
    logic [WAIT_W-1:0] r_wait_ticks;
    logic [RX_AW-1:0]  r_rx_wr, n_rx_wr, r_rx_rd, n_rx_rd;
    logic              r_rx_refusing, n_rx_refusing;
    logic              r_rx_stale, n_rx_stale;
    logic              r_rx_ack, n_rx_ack;
    logic [TX_AW-1:0]  r_tx_wr, n_tx_wr, r_tx_rd, n_tx_rd;
    logic              r_zlp_owed, n_zlp_owed;
    logic              r_gave_up, n_gave_up;
    logic [WAIT_W-1:0] r_wait_rem, n_wait_rem;
    logic              r_wait_armed, n_wait_armed;
    logic [CNT_W-1:0]  r_tx_cnt, n_tx_cnt;

    // Result register.
    logic              r_out_valid;
    t_kind             r_kind;
    logic [DATA_W-1:0] r_out_byte;
    logic              r_last;
    logic              r_rx_acc;

    logic [DATA_W-1:0] rx_q, tx_q;
    logic [RX_AW-1:0]  rx_wr_nx, rx_rd_eff;
    logic [TX_AW-1:0]  tx_wr_nx, tx_rd_nx;
    logic              rx_full, tx_full, tx_empty, rx_avail, flush_go, tx_last;
    logic              out_free, rx_we, tx_we;
    logic [WAIT_W-1:0] wait_dec;
    logic              emit;
    t_kind             e_kind;
    logic [DATA_W-1:0] e_byte;
    logic              e_last;

    assign rx_wr_nx  = rx_ptr_next(r_rx_wr);
    assign rx_full   = (rx_wr_nx == r_rx_rd);
    assign rx_rd_eff = r_rx_stale ? r_rx_wr : r_rx_rd;
    assign rx_avail  = (rx_rd_eff != r_rx_wr);
    assign tx_wr_nx  = tx_ptr_next(r_tx_wr);
    assign tx_rd_nx  = tx_ptr_next(r_tx_rd);
    assign tx_full   = (tx_wr_nx == r_tx_rd);
    assign tx_empty  = (r_tx_rd == r_tx_wr);
    assign flush_go  = (!tx_empty || r_zlp_owed) && r_ep_ready && r_open;
    assign tx_last   = (tx_rd_nx == r_tx_wr) || (r_tx_cnt == CNT_W'(PACKET_BYTES - 1));
    assign out_free  = !r_out_valid || i_out_ready;
    assign wait_dec  = (r_wait_rem != '0) ? r_wait_rem - WAIT_W'(1) : r_wait_rem;
    assign rx_we     = i_cmd.exec && (r_mode == MODE_RX_BYTE) && !rx_full;
    assign tx_we     = i_cmd.exec && (r_mode == MODE_WRITE) && !tx_full;

    usrb_ram #(.WIDTH(DATA_W), .DEPTH(RX_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_wr),
        .i_wdata (r_byte),
        .i_raddr (r_rx_rd),
        .o_rdata (rx_q)
    );

    usrb_ram #(.WIDTH(DATA_W), .DEPTH(TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_wr),
        .i_wdata (r_byte),
        .i_raddr (r_tx_rd),
        .o_rdata (tx_q)
    );

    always_comb begin
        n_rx_wr       = r_rx_wr;
        n_rx_rd       = r_rx_rd;
        n_rx_refusing = r_rx_refusing;
        n_rx_stale    = r_rx_stale;
        n_rx_ack      = r_rx_ack;
        n_tx_wr       = r_tx_wr;
        n_tx_rd       = r_tx_rd;
        n_zlp_owed    = r_zlp_owed;
        n_gave_up     = r_gave_up;
        n_wait_rem    = r_wait_rem;
        n_wait_armed  = r_wait_armed;
        n_tx_cnt      = r_tx_cnt;
        emit          = 1'b0;
        e_kind        = KIND_NONE;
        e_byte        = '0;
        e_last        = 1'b1;

        if (i_cmd.exec) begin
            emit = 1'b1;
            case (r_mode)
                MODE_RX_BYTE: begin
                    if (!rx_full) begin
                        n_rx_wr = rx_wr_nx;
                    end
                    if (r_pend && !rx_room_ok(r_rx_rd, n_rx_wr)) begin
                        n_rx_ack      = 1'b0;
                        n_rx_refusing = 1'b1;
                    end
                end
                MODE_READ: begin
                    n_rx_stale = 1'b0;
                    n_rx_rd    = rx_rd_eff;
                    if (r_rx_refusing && rx_room_ok(rx_rd_eff, r_rx_wr)) begin
                        n_rx_refusing = 1'b0;
                        n_rx_ack      = 1'b1;
                    end
                    // A byte is fetched first; only an empty ring answers now.
                    if (rx_avail) begin
                        emit = 1'b0;
                    end else begin
                        e_kind = KIND_READ_EMPTY;
                    end
                end
                MODE_WRITE: begin
                    if (!tx_full) begin
                        n_tx_wr      = tx_wr_nx;
                        n_wait_armed = 1'b0;
                        e_kind       = KIND_WR_ACCEPT;
                    end else if (r_gave_up || !r_open) begin
                        e_kind = KIND_WR_DROP;
                    end else if (r_wait_armed) begin
                        e_kind = KIND_WR_WAIT;
                    end else if (r_wait_ticks == '0) begin
                        n_gave_up = 1'b1;
                        e_kind    = KIND_WR_DROP;
                    end else begin
                        n_wait_armed = 1'b1;
                        n_wait_rem   = r_wait_ticks;
                        e_kind       = KIND_WR_WAIT;
                    end
                end
                MODE_FLUSH: begin
                    if (flush_go) begin
                        n_gave_up = 1'b0;
                        n_tx_cnt  = '0;
                        if (tx_empty) begin
                            n_zlp_owed = 1'b0;
                            e_kind     = KIND_ZLP;
                        end else begin
                            emit = 1'b0;
                        end
                    end
                end
                MODE_EP_RESET: begin
                    n_rx_refusing = 1'b0;
                    n_gave_up     = 1'b0;
                    n_rx_stale    = 1'b1;
                end
                MODE_DROP_TX: begin
                    n_tx_rd      = r_tx_wr;
                    n_zlp_owed   = 1'b0;
                    n_gave_up    = 1'b0;
                    n_wait_armed = 1'b0;
                end
                MODE_REARM: begin
                    n_rx_refusing = !rx_room_ok(r_rx_rd, r_rx_wr);
                    n_rx_ack      = rx_room_ok(r_rx_rd, r_rx_wr);
                end
                MODE_TICK: begin
                    if (r_wait_armed) begin
                        if (!tx_full) begin
                            n_wait_armed = 1'b0;
                        end else begin
                            n_wait_rem = wait_dec;
                            if (wait_dec == '0) begin
                                n_gave_up    = 1'b1;
                                n_wait_armed = 1'b0;
                            end
                        end
                    end
                end
                default: begin
                    e_kind = KIND_NONE;
                end
            endcase
        end

        if (i_cmd.rx_emit) begin
            emit    = 1'b1;
            e_kind  = KIND_READ_BYTE;
            e_byte  = rx_q;
            n_rx_rd = rx_ptr_next(r_rx_rd);
        end

        if (i_cmd.tx_emit) begin
            emit     = 1'b1;
            e_kind   = KIND_PKT_BYTE;
            e_byte   = tx_q;
            e_last   = tx_last;
            n_tx_rd  = tx_rd_nx;
            n_tx_cnt = r_tx_cnt + CNT_W'(1);
            if (tx_last) begin
                n_zlp_owed = (r_tx_cnt == CNT_W'(PACKET_BYTES - 1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode     <= t_mode'(i_mode);
            r_byte     <= i_byte_in;
            r_pend     <= i_packet_end;
            r_ep_ready <= i_endpoint_ready;
            r_open     <= i_port_open;
        end
        if (emit) begin
            r_kind     <= e_kind;
            r_out_byte <= e_byte;
            r_last     <= e_last;
            r_rx_acc   <= n_rx_ack;
        end
        r_wait_rem <= n_wait_rem;
        r_tx_cnt   <= n_tx_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_ticks  <= WAIT_TICKS_RESET;
            r_rx_wr       <= '0;
            r_rx_rd       <= '0;
            r_rx_refusing <= 1'b0;
            r_rx_stale    <= 1'b0;
            r_rx_ack      <= 1'b1;
            r_tx_wr       <= '0;
            r_tx_rd       <= '0;
            r_zlp_owed    <= 1'b0;
            r_gave_up     <= 1'b0;
            r_wait_armed  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wait_ticks <= i_cfg_wdata;
            end
            r_rx_wr       <= n_rx_wr;
            r_rx_rd       <= n_rx_rd;
            r_rx_refusing <= n_rx_refusing;
            r_rx_stale    <= n_rx_stale;
            r_rx_ack      <= n_rx_ack;
            r_tx_wr       <= n_tx_wr;
            r_tx_rd       <= n_tx_rd;
            r_zlp_owed    <= n_zlp_owed;
            r_gave_up     <= n_gave_up;
            r_wait_armed  <= n_wait_armed;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.mode     = r_mode;
    assign o_status.rx_avail = rx_avail;
    assign o_status.flush_go = flush_go;
    assign o_status.tx_avail = !tx_empty;
    assign o_status.tx_last  = tx_last;
    assign o_status.out_free = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_byte_out     = r_out_byte;
    assign o_last         = r_last;
    assign o_rx_accepting = r_rx_acc;

endmodule

@@ rtl/core/usb_serial_ring_bridge_core.sv @@
// ----------------------------------------------------------------------------
// usb_serial_ring_bridge_core
// Serial-over-USB buffer bridge with a receive ring and a transmit ring.
// ----------------------------------------------------------------------------
// The bridge takes one command item at a time and answers with one or more
// result transfers, the final one marked by last. Simple commands (receive
// byte, write, endpoint reset, drop, rearm, tick, a flush that sends nothing,
// and a read of an empty ring) load the result register in their execute
// step. A read that returns a byte adds a fetch and an emit step, and a flush
// adds a fetch and an emit step per packet byte, up to PACKET_BYTES bytes.
// These steps come from the registered read port of the ring memories: every
// byte leaving a ring is fetched first and presented afterwards. A stall on
// the result channel simply stretches the sequence; the next item is
// accepted once the current item's last result has been loaded into the
// result register, so it may overlap with that result waiting to be taken.
// The wait_ticks register is written through i_cfg_we and i_cfg_wdata and
// must only be changed while the block is idle. Both ring memories hold no
// meaningful data after reset and need no clearing pass, because only slots
// between the read and write pointers are ever delivered.
// ----------------------------------------------------------------------------
module usb_serial_ring_bridge_core import usrb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WAIT_W-1:0] i_cfg_wdata,
    usrb_in_if.sink           i_in,
    usrb_out_if.source        o_out
);

    // The controller and the datapath talk only through these two bundles.
    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    // The controller decides when an item is captured, when its update is
    // applied and when a byte fetched from a ring memory is presented.
    usrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath owns both rings, all flags, the stall deadline and the
    // result register that decouples the result channel from the sequencer.
    usrb_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_mode           (i_in.mode),
        .i_byte_in        (i_in.byte_in),
        .i_packet_end     (i_in.packet_end),
        .i_endpoint_ready (i_in.endpoint_ready),
        .i_port_open      (i_in.port_open),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_kind           (o_out.kind),
        .o_byte_out       (o_out.byte_out),
        .o_last           (o_out.last),
        .o_rx_accepting   (o_out.rx_accepting)
    );

    assign i_in.ready = in_ready;

`ifndef SYNTHESIS
    // The sequencer issues at most one command per cycle.
    a_one_cmd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.latch, cmd.exec, cmd.rx_emit, cmd.tx_emit}))
        else $error("more than one datapath command in a cycle");

    // Nothing is loaded into the result register unless it is free.
    a_emit_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.exec || cmd.rx_emit || cmd.tx_emit) |-> status.out_free)
        else $error("result register overwritten while occupied");

    // After a transfer on the input channel the block is busy with that item.
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted again before the item was executed");
`endif

endmodule
